// ----- sv/rtp_dpk_pkg.sv -----
// ----------------------------------------------------------------------------
// RTP H.264 depacketizer package
// Shared types, constants and helper functions for the depacketizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rtp_dpk_pkg;

    // Fixed RTP header length and the byte positions that are interpreted.
    localparam int unsigned RTP_HEADER_BYTES = 12;
    localparam logic [15:0] HDR_LEN      = 16'(RTP_HEADER_BYTES);
    localparam logic [15:0] IDX_PT       = 16'd1;
    localparam logic [15:0] IDX_SEQ_HI   = 16'd2;
    localparam logic [15:0] IDX_SEQ_LO   = 16'd3;
    localparam logic [15:0] IDX_TS_FIRST = 16'd4;
    localparam logic [15:0] IDX_TS_LAST  = 16'd7;
    localparam logic [15:0] IDX_FU_HDR   = 16'(RTP_HEADER_BYTES + 1);

    // NAL unit types and masks.
    localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
    localparam logic [4:0] NAL_FU_A       = 5'd28;
    localparam logic [7:0] NRI_MASK       = 8'he0;
    localparam logic [7:0] TYPE_MASK      = 8'h1f;

    // Configuration register indexes and reset values.
    localparam logic CFG_IDX_PT       = 1'b0;
    localparam logic CFG_IDX_CAPACITY = 1'b1;
    localparam logic [6:0]  PT_RESET       = 7'd96;
    localparam logic [15:0] CAPACITY_RESET = 16'd1500;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_WRONG_PT  = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
    localparam logic [2:0] ST_TOO_SHORT = 3'd3;
    localparam logic [2:0] ST_OVER_CAP  = 3'd4;

    // Result kinds.
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Emitter steps: four start code bytes, the data byte, then the status.
    localparam logic [2:0] STEP_SC_FIRST = 3'd0;
    localparam logic [2:0] STEP_BYTE     = 3'd4;
    localparam logic [2:0] STEP_STATUS   = 3'd5;

    // Packet handling mode.
    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_FUA    = 2'd2,
        MODE_DROP   = 2'd3
    } pkt_mode_t;

    // One input transfer.
    typedef struct packed {
        logic [7:0]  byte_value;
        logic        first_byte;
        logic [15:0] packet_length;
    } rtp_in_t;

    // One result transfer.
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  out_byte;
        logic [2:0]  status_code;
        logic        nal_start;
        logic        nal_end;
        logic [4:0]  nal_frame_type;
        logic [6:0]  payload_type_seen;
        logic [15:0] sequence_number;
        logic [31:0] time_stamp;
        logic [31:0] sync_source;
        logic [15:0] output_length;
        logic        last_of_packet;
    } rtp_out_t;

    // Work handed from the parser to the emitter for one accepted byte.
    typedef struct packed {
        logic       has_job;
        logic [2:0] first_step;
        logic [2:0] last_step;
        logic [7:0] data_byte;
    } job_req_t;

    // Packet status as held by the parser registers.
    typedef struct packed {
        logic [2:0]  code;
        logic        start_flag;
        logic        end_flag;
        logic [4:0]  frame_type;
        logic [6:0]  pt;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [31:0] ssrc;
        logic [15:0] count;
    } status_info_t;

    // Annex-B start code 00 00 00 01.
    function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
        return (idx == 2'd3) ? 8'h01 : 8'h00;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rtp_dpk_parser.sv -----
// ----------------------------------------------------------------------------
// RTP depacketizer parser
// Holds the packet state, decodes each accepted byte and tells the emitter
// which results that byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_dpk_parser
    import rtp_dpk_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_fire,
    input  rtp_in_t           in_data,
    input  wire logic [6:0]   video_payload_type,
    input  wire logic [15:0]  output_capacity,
    output job_req_t          job_req,
    output status_info_t      status_info
);

    // State registers.
    logic [15:0] byte_index_reg, byte_index_next;
    logic [15:0] length_reg, length_next;
    pkt_mode_t   mode_reg, mode_next;
    logic [2:0]  pending_reg, pending_next;
    logic [6:0]  pt_reg, pt_next;
    logic [15:0] seq_reg, seq_next;
    logic [31:0] ts_reg, ts_next;
    logic [31:0] ssrc_reg, ssrc_next;
    logic [7:0]  fu_ind_reg, fu_ind_next;
    logic        start_reg, start_next;
    logic        end_reg, end_next;
    logic [4:0]  ftype_reg, ftype_next;
    logic [15:0] count_reg, count_next;

    // Decode results shared by the next-state and output blocks.
    logic        first;
    logic        active;
    logic [15:0] len_cur;
    logic [15:0] idx_cur;
    pkt_mode_t   mode_cur;
    logic [15:0] payload;
    logic [4:0]  nal_type;
    logic        emit_sc;
    logic        emit_byte;
    logic [7:0]  byte_out;
    logic        rej;
    logic [2:0]  rej_code;
    pkt_mode_t   mode_set;
    logic        set_flags;
    logic        flag_s;
    logic        flag_e;
    logic        set_ftype;
    logic [4:0]  ftype_val;
    logic        capture_fu;
    logic [15:0] idx_inc;
    logic        ends;
    logic [16:0] need_single;
    logic [16:0] need_fu;

    // Byte decode: effective packet state after a possible new-packet reset.
    always_comb
    begin
        first     = in_data.first_byte;
        len_cur   = first ? ((in_data.packet_length == 16'd0) ? 16'd1 : in_data.packet_length)
                          : length_reg;
        idx_cur   = first ? 16'd0 : byte_index_reg;
        mode_cur  = first ? MODE_HEADER : mode_reg;
        active    = first || (byte_index_reg < length_reg);
        payload   = (len_cur > HDR_LEN) ? (len_cur - HDR_LEN) : 16'd0;
        nal_type  = in_data.byte_value[4:0];
        need_single = {1'b0, payload} + 17'd4;
        need_fu     = {1'b0, payload} - 17'd2
                      + (in_data.byte_value[7] ? 17'd5 : 17'd0);

        emit_sc    = 1'b0;
        emit_byte  = 1'b0;
        byte_out   = in_data.byte_value;
        rej        = 1'b0;
        rej_code   = ST_OK;
        mode_set   = mode_cur;
        set_flags  = 1'b0;
        flag_s     = 1'b0;
        flag_e     = 1'b0;
        set_ftype  = 1'b0;
        ftype_val  = nal_type;
        capture_fu = 1'b0;

        if (idx_cur < HDR_LEN)
        begin
            // Payload type check on header byte 1.
            if ((idx_cur == IDX_PT) && (in_data.byte_value[6:0] != video_payload_type)
                && (mode_cur == MODE_HEADER))
            begin
                rej      = 1'b1;
                rej_code = ST_WRONG_PT;
            end
        end
        else
        begin
            unique case (mode_cur)
                MODE_HEADER:
                begin
                    if (nal_type <= NAL_SINGLE_MAX)
                    begin
                        if (need_single > {1'b0, output_capacity})
                        begin
                            rej      = 1'b1;
                            rej_code = ST_OVER_CAP;
                        end
                        else
                        begin
                            emit_sc   = 1'b1;
                            emit_byte = 1'b1;
                            set_flags = 1'b1;
                            flag_s    = 1'b1;
                            flag_e    = 1'b1;
                            set_ftype = 1'b1;
                            mode_set  = MODE_SINGLE;
                        end
                    end
                    else if (nal_type == NAL_FU_A)
                    begin
                        if (payload < 16'd3)
                        begin
                            rej      = 1'b1;
                            rej_code = ST_TOO_SHORT;
                        end
                        else
                        begin
                            capture_fu = 1'b1;
                            mode_set   = MODE_FUA;
                        end
                    end
                    else
                    begin
                        rej      = 1'b1;
                        rej_code = ST_BAD_TYPE;
                    end
                end
                MODE_SINGLE:
                begin
                    emit_byte = 1'b1;
                end
                MODE_FUA:
                begin
                    if (idx_cur == IDX_FU_HDR)
                    begin
                        if (need_fu > {1'b0, output_capacity})
                        begin
                            rej      = 1'b1;
                            rej_code = ST_OVER_CAP;
                        end
                        else
                        begin
                            // A start fragment gets a start code and the rebuilt header.
                            if (in_data.byte_value[7])
                            begin
                                emit_sc   = 1'b1;
                                emit_byte = 1'b1;
                                byte_out  = (fu_ind_reg & NRI_MASK)
                                            | (in_data.byte_value & TYPE_MASK);
                                set_ftype = 1'b1;
                            end
                            set_flags = 1'b1;
                            flag_s    = in_data.byte_value[7];
                            flag_e    = in_data.byte_value[6];
                        end
                    end
                    else
                    begin
                        emit_byte = 1'b1;
                    end
                end
                MODE_DROP:
                begin
                end
                default:
                begin
                end
            endcase
        end

        if (rej)
        begin
            mode_set = MODE_DROP;
        end

        // End of packet; a packet still waiting for its NAL type is too short.
        idx_inc = idx_cur + 16'd1;
        ends    = (idx_inc >= len_cur);
        if (ends && (mode_set == MODE_HEADER))
        begin
            rej      = 1'b1;
            rej_code = ST_TOO_SHORT;
            mode_set = MODE_DROP;
        end
    end

    // Next state of the packet registers.
    always_comb
    begin
        byte_index_next = byte_index_reg;
        length_next     = length_reg;
        mode_next       = mode_reg;
        pending_next    = pending_reg;
        pt_next         = pt_reg;
        seq_next        = seq_reg;
        ts_next         = ts_reg;
        ssrc_next       = ssrc_reg;
        fu_ind_next     = fu_ind_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        ftype_next      = ftype_reg;
        count_next      = count_reg;

        if (in_fire && active)
        begin
            length_next  = len_cur;
            pt_next      = first ? 7'd0 : pt_reg;
            seq_next     = first ? 16'd0 : seq_reg;
            ts_next      = first ? 32'd0 : ts_reg;
            ssrc_next    = first ? 32'd0 : ssrc_reg;
            fu_ind_next  = first ? 8'd0 : fu_ind_reg;
            start_next   = first ? 1'b0 : start_reg;
            end_next     = first ? 1'b0 : end_reg;
            pending_next = first ? ST_OK : pending_reg;
            count_next   = first ? 16'd0 : count_reg;

            // Header field capture, most significant byte first.
            if (idx_cur == IDX_PT)
            begin
                pt_next = in_data.byte_value[6:0];
            end
            else if ((idx_cur == IDX_SEQ_HI) || (idx_cur == IDX_SEQ_LO))
            begin
                seq_next = {seq_next[7:0], in_data.byte_value};
            end
            else if ((idx_cur >= IDX_TS_FIRST) && (idx_cur <= IDX_TS_LAST))
            begin
                ts_next = {ts_next[23:0], in_data.byte_value};
            end
            else if ((idx_cur > IDX_TS_LAST) && (idx_cur < HDR_LEN))
            begin
                ssrc_next = {ssrc_next[23:0], in_data.byte_value};
            end

            if (capture_fu)
            begin
                fu_ind_next = in_data.byte_value;
            end
            if (set_ftype)
            begin
                ftype_next = ftype_val;
            end
            if (set_flags)
            begin
                start_next = flag_s;
                end_next   = flag_e;
            end
            if (rej)
            begin
                pending_next = rej_code;
                start_next   = 1'b0;
                end_next     = 1'b0;
            end

            count_next = count_next + (emit_sc ? 16'd5 : (emit_byte ? 16'd1 : 16'd0));
            mode_next  = mode_set;
            byte_index_next = ends ? len_cur : idx_inc;
        end
    end

    // Work for the emitter: a contiguous run of steps ending at the byte or the status.
    always_comb
    begin
        job_req.has_job    = in_fire && active && (emit_byte || ends);
        job_req.first_step = emit_sc ? STEP_SC_FIRST : (emit_byte ? STEP_BYTE : STEP_STATUS);
        job_req.last_step  = ends ? STEP_STATUS : STEP_BYTE;
        job_req.data_byte  = byte_out;
    end

    // Status as held after the last byte of a packet.
    assign status_info = '{code:       pending_reg,
                           start_flag: start_reg,
                           end_flag:   end_reg,
                           frame_type: ftype_reg,
                           pt:         pt_reg,
                           seq:        seq_reg,
                           ts:         ts_reg,
                           ssrc:       ssrc_reg,
                           count:      count_reg};

    // Packet state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            length_reg     <= '0;
            mode_reg       <= MODE_HEADER;
            pending_reg    <= ST_OK;
            pt_reg         <= '0;
            seq_reg        <= '0;
            ts_reg         <= '0;
            ssrc_reg       <= '0;
            fu_ind_reg     <= '0;
            start_reg      <= 1'b0;
            end_reg        <= 1'b0;
            ftype_reg      <= '0;
            count_reg      <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            length_reg     <= length_next;
            mode_reg       <= mode_next;
            pending_reg    <= pending_next;
            pt_reg         <= pt_next;
            seq_reg        <= seq_next;
            ts_reg         <= ts_next;
            ssrc_reg       <= ssrc_next;
            fu_ind_reg     <= fu_ind_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
            ftype_reg      <= ftype_next;
            count_reg      <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rtp_dpk_emitter.sv -----
// ----------------------------------------------------------------------------
// RTP depacketizer emitter
// Holds the pending results of one accepted byte and presents them one per
// cycle while out_ready is high: start code, data byte, closing status.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_dpk_emitter
    import rtp_dpk_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  job_req_t     job_req,
    input  status_info_t status_info,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output rtp_out_t     out_data
);

    logic       job_valid_reg, job_valid_next;
    logic [2:0] step_reg, step_next;
    logic [2:0] last_reg, last_next;
    logic [7:0] byte_reg, byte_next;
    logic       out_fire;
    logic       on_last;
    logic       status_ok;

    assign out_fire = out_valid && out_ready;
    assign on_last  = (step_reg == last_reg);

    // A new byte is taken while the final result of the current one transfers.
    assign in_ready  = !job_valid_reg || (out_ready && on_last);
    assign out_valid = job_valid_reg;

    // Step sequencing.
    always_comb
    begin
        job_valid_next = job_valid_reg;
        step_next      = step_reg;
        last_next      = last_reg;
        byte_next      = byte_reg;
        if (job_req.has_job)
        begin
            job_valid_next = 1'b1;
            step_next      = job_req.first_step;
            last_next      = job_req.last_step;
            byte_next      = job_req.data_byte;
        end
        else if (out_fire)
        begin
            if (on_last)
            begin
                job_valid_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 3'd1;
            end
        end
    end

    // Result assembly for the current step.
    always_comb
    begin
        status_ok = (status_info.code == ST_OK);
        out_data  = '0;
        if (step_reg == STEP_STATUS)
        begin
            out_data.result_kind       = KIND_STATUS;
            out_data.status_code       = status_info.code;
            out_data.nal_start         = status_ok && status_info.start_flag;
            out_data.nal_end           = status_ok && status_info.end_flag;
            out_data.nal_frame_type    = status_info.frame_type;
            out_data.payload_type_seen = status_info.pt;
            out_data.sequence_number   = status_info.seq;
            out_data.time_stamp        = status_info.ts;
            out_data.sync_source       = status_info.ssrc;
            out_data.output_length     = status_ok ? status_info.count : 16'd0;
            out_data.last_of_packet    = 1'b1;
        end
        else if (step_reg == STEP_BYTE)
        begin
            out_data.result_kind = KIND_BYTE;
            out_data.out_byte    = byte_reg;
        end
        else
        begin
            out_data.result_kind = KIND_BYTE;
            out_data.out_byte    = start_code_byte(step_reg[1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            step_reg      <= STEP_SC_FIRST;
            last_reg      <= STEP_STATUS;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
        end
    end

    // Data byte of the current job.
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

`default_nettype wire

// ----- sv/rtp_h264_depacketizer.sv -----
// ----------------------------------------------------------------------------
// RTP H.264 depacketizer
// Turns RTP packets carrying single NAL units or FU-A fragments into an
// Annex-B byte stream with one status result closing each packet.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------
//  in       | input     | in_valid / in_ready        | in_data (rtp_in_t)
//  out      | output    | out_valid / out_ready      | out_data (rtp_out_t)
//  cfg      | input     | cfg_write_en, no wait      | cfg_index, cfg_data
//
//  Each accepted byte is decoded in the cycle of its transfer and yields up to
//  six results, presented one per cycle while out_ready is high from the
//  emitter's step register. A byte with several results holds off input until
//  the last of them transfers. The next byte is taken in the cycle its
//  predecessor's final result transfers. Reset clears all packet state and
//  loads payload type 96 and capacity 1500. A stalled output holds its result
//  and blocks input until it transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_h264_depacketizer
    import rtp_dpk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  rtp_in_t          in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output rtp_out_t         out_data,
    input  wire logic        cfg_write_en,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [6:0]   pt_cfg_reg;
    logic [15:0]  cap_cfg_reg;
    logic         in_fire;
    job_req_t     job_req;
    status_info_t status_info;

    assign in_fire = in_valid && in_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_cfg_reg  <= PT_RESET;
            cap_cfg_reg <= CAPACITY_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_IDX_PT:       pt_cfg_reg  <= cfg_data[6:0];
                CFG_IDX_CAPACITY: cap_cfg_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    rtp_dpk_parser u_parser (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_fire            (in_fire),
        .in_data            (in_data),
        .video_payload_type (pt_cfg_reg),
        .output_capacity    (cap_cfg_reg),
        .job_req            (job_req),
        .status_info        (status_info)
    );

    rtp_dpk_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_req     (job_req),
        .status_info (status_info),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    // With nothing pending the block always takes input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with no result pending");

    // A result waiting on a stalled output blocks new input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while a result is stalled");

    // A status result closes the packet and carries no stream byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.result_kind) |-> (out_data.last_of_packet
                                                 && (out_data.out_byte == 8'd0)))
        else $error("malformed status result");

    // A rejected packet reports no emitted bytes and no NAL flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.result_kind && (out_data.status_code != ST_OK))
        |-> ((out_data.output_length == 16'd0) && !out_data.nal_start
             && !out_data.nal_end))
        else $error("rejected packet reports output");

endmodule

`default_nettype wire
